// File: rtl/rtccal_pkg.sv
// Shared types, constants and calendar helper functions for the RTC calendar tick block.
// Used by every module under rtl; no dependencies.
package rtccal_pkg;

   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned MSEC_W   = 10;
   localparam int unsigned EPOCH_W  = 32;
   localparam int unsigned RATE_W   = 10;
   localparam int unsigned CSR_W    = 10;

   localparam logic [MSEC_W-1:0]   MSEC_PER_SEC = 10'd1000;
   localparam logic [RATE_W-1:0]   RATE_MAX     = 10'd1000;
   localparam logic [SECOND_W-1:0] SECOND_MAX   = 6'd59;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX   = 6'd59;
   localparam logic [HOUR_W-1:0]   HOUR_MAX     = 5'd23;
   localparam logic [MONTH_W-1:0]  MONTH_MAX    = 4'd12;
   localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
   localparam logic [YEAR_W-1:0]   YEAR_MIN     = 12'd1970;
   localparam logic [YEAR_W-1:0]   YEAR_MAX     = 12'd2105;

   // 2^20 / 25 rounded up; exact quotient for any 12-bit year
   localparam logic [31:0] RECIP_25 = 32'd41944;

   typedef enum logic {
      CSR_TICK_RATE  = 1'b0,
      CSR_TIME_VALID = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [MSEC_W-1:0]   msec;
      logic [EPOCH_W-1:0]  epoch;
   } time_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [EPOCH_W-1:0]  epoch;
   } set_type;

   typedef struct packed {
      logic              busy;
      logic              ok;
      logic [MSEC_W-1:0] step;
   } rate_type;

   localparam time_type TIME_RESET = '{
      year:   YEAR_MIN,
      month:  4'd1,
      day:    5'd1,
      hour:   '0,
      minute: '0,
      second: '0,
      msec:   '0,
      epoch:  '0
   };

   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      logic [31:0]       prod;
      logic [YEAR_W-1:0] q;
      logic [YEAR_W-1:0] r;
      logic              div25;
      prod  = {20'd0, y} * RECIP_25;
      q     = prod[31:20];
      r     = y - YEAR_W'(q * 12'd25);
      div25 = (r == '0);
      return (div25 && (y[3:0] == 4'd0)) || (!div25 && (y[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] days_of_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/rtccal_rate.sv
// Tick rate register and millisecond step calculation (1000 / rate, one quotient bit a cycle).
// Depends on rtccal_pkg.
module rtccal_rate (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [rtccal_pkg::CSR_W-1:0]    csr_wdata,
   output rtccal_pkg::rate_type            rate
);

   logic                              busy_ff, busy_in;
   logic                              ok_ff, ok_in;
   logic [rtccal_pkg::MSEC_W-1:0]     step_ff, step_in;
   logic [3:0]                        cnt_ff, cnt_in;
   logic [rtccal_pkg::RATE_W-1:0]     rem_ff, rem_in;
   logic [rtccal_pkg::MSEC_W-1:0]     quo_ff, quo_in;
   logic [rtccal_pkg::RATE_W-1:0]     div_ff, div_in;
   logic [rtccal_pkg::RATE_W:0]       shifted;
   logic                              qbit;
   logic                              rate_wr;
   logic                              rate_good;

   assign rate_wr   = csr_wr_en && (csr_index == rtccal_pkg::CSR_TICK_RATE);
   assign rate_good = (csr_wdata != '0) && (csr_wdata <= rtccal_pkg::RATE_MAX);
   assign shifted   = {rem_ff, rtccal_pkg::MSEC_PER_SEC[cnt_ff]};
   assign qbit      = (shifted >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      ok_in   = ok_ff;
      step_in = step_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (busy_ff) begin
         rem_in = qbit ? rtccal_pkg::RATE_W'(shifted - {1'b0, div_ff})
                       : shifted[rtccal_pkg::RATE_W-1:0];
         quo_in = {quo_ff[rtccal_pkg::MSEC_W-2:0], qbit};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            step_in = quo_in;
         end
      end
      if (rate_wr) begin
         ok_in   = rate_good;
         busy_in = rate_good;
         cnt_in  = 4'(rtccal_pkg::MSEC_W - 1);
         rem_in  = '0;
         quo_in  = '0;
         div_in  = csr_wdata[rtccal_pkg::RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ok_ff   <= 1'b1;
         step_ff <= rtccal_pkg::MSEC_W'(1);
      end else begin
         busy_ff <= busy_in;
         ok_ff   <= ok_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rate.busy = busy_ff;
   assign rate.ok   = ok_ff;
   assign rate.step = step_ff;

endmodule

// File: rtl/rtccal_core.sv
// Calendar state registers with load and single-carry tick cascade.
// Depends on rtccal_pkg.
module rtccal_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load_en,
   input  logic                            tick_en,
   input  rtccal_pkg::set_type             set,
   input  logic [rtccal_pkg::MSEC_W-1:0]   step,
   output rtccal_pkg::time_type            time_q,
   output rtccal_pkg::time_type            time_next
);

   rtccal_pkg::time_type              time_ff, time_in;
   logic [rtccal_pkg::MSEC_W:0]       msec_sum;
   logic                              c_sec;
   logic [rtccal_pkg::SECOND_W:0]     sec_inc;
   logic [rtccal_pkg::MINUTE_W:0]     min_inc;
   logic [rtccal_pkg::HOUR_W:0]       hour_inc;
   logic [rtccal_pkg::DAY_W:0]        day_inc;
   logic [rtccal_pkg::MONTH_W:0]      month_inc;
   logic [rtccal_pkg::YEAR_W:0]       year_inc;
   logic [rtccal_pkg::DAY_W-1:0]      mlen;
   logic                              w_sec, w_min, w_hour, w_day, w_month, w_year;

   always_comb begin
      msec_sum  = {1'b0, time_ff.msec} + {1'b0, step};
      c_sec     = msec_sum >= {1'b0, rtccal_pkg::MSEC_PER_SEC};
      sec_inc   = {1'b0, time_ff.second} + 7'd1;
      min_inc   = {1'b0, time_ff.minute} + 7'd1;
      hour_inc  = {1'b0, time_ff.hour} + 6'd1;
      day_inc   = {1'b0, time_ff.day} + 6'd1;
      month_inc = {1'b0, time_ff.month} + 5'd1;
      year_inc  = {1'b0, time_ff.year} + 13'd1;
      mlen      = rtccal_pkg::days_of_month(time_ff.month,
                                            rtccal_pkg::leap_year(time_ff.year));
      w_sec     = sec_inc > {1'b0, rtccal_pkg::SECOND_MAX};
      w_min     = min_inc > {1'b0, rtccal_pkg::MINUTE_MAX};
      w_hour    = hour_inc > {1'b0, rtccal_pkg::HOUR_MAX};
      w_day     = day_inc > {1'b0, mlen};
      w_month   = month_inc > {1'b0, rtccal_pkg::MONTH_MAX};
      w_year    = year_inc > {1'b0, rtccal_pkg::YEAR_MAX};

      time_in = time_ff;
      if (load_en) begin
         time_in.year   = set.year;
         time_in.month  = set.month;
         time_in.day    = set.day;
         time_in.hour   = set.hour;
         time_in.minute = set.minute;
         time_in.second = set.second;
         time_in.epoch  = set.epoch;
         time_in.msec   = '0;
      end else if (tick_en) begin
         if (c_sec) begin
            time_in.msec   = rtccal_pkg::MSEC_W'(msec_sum - {1'b0, rtccal_pkg::MSEC_PER_SEC});
            time_in.epoch  = time_ff.epoch + 32'd1;
            time_in.second = w_sec ? '0 : sec_inc[rtccal_pkg::SECOND_W-1:0];
            if (w_sec) begin
               time_in.minute = w_min ? '0 : min_inc[rtccal_pkg::MINUTE_W-1:0];
               if (w_min) begin
                  time_in.hour = w_hour ? '0 : hour_inc[rtccal_pkg::HOUR_W-1:0];
                  if (w_hour) begin
                     time_in.day = w_day ? 5'd1 : day_inc[rtccal_pkg::DAY_W-1:0];
                     if (w_day) begin
                        time_in.month = w_month ? 4'd1
                                                : month_inc[rtccal_pkg::MONTH_W-1:0];
                        if (w_month) begin
                           time_in.year = w_year ? rtccal_pkg::YEAR_MIN
                                                 : year_inc[rtccal_pkg::YEAR_W-1:0];
                        end
                     end
                  end
               end
            end
         end else begin
            time_in.msec = msec_sum[rtccal_pkg::MSEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= rtccal_pkg::TIME_RESET;
      end else begin
         time_ff <= time_in;
      end
   end

   assign time_q    = time_ff;
   assign time_next = time_in;

endmodule

// File: rtl/rtccal_fifo.sv
// Two-entry result buffer between the calendar update and the response channel.
// Depends on rtccal_pkg.
module rtccal_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rtccal_pkg::time_type   push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output rtccal_pkg::time_type   head
);

   rtccal_pkg::time_type   entry_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = count_ff[1];
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/rtc_calendar_tick.sv
// Real-time clock calendar: every request transfer is a tick or a load, and each yields one
// response carrying the full date, time and epoch count after that request. Requests are taken
// one per cycle while req_tready is high, and each result is registered in a two-entry result
// buffer, which keeps requests flowing while one response waits. Writing an in-range value to
// the tick rate register starts a step calculation (1000 / rate) in a bit-serial divider,
// during which req_tready is low; an out-of-range rate disables ticks at once.
// Ticks are ignored until time_valid is written with 1. Reset gives 1970-01-01 00:00:00.000.
module rtc_calendar_tick (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // set_year, set_month, set_day, set_hour, set_minute, set_second, set_epoch, zero pad
   input  logic [71:0]                       req_tdata,
   // mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // year, month, day, hour, minute, second, msec, epoch
   output logic [79:0]                       rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [rtccal_pkg::CSR_W-1:0]      csr_wdata
);

   rtccal_pkg::rate_type   rate;
   rtccal_pkg::set_type    set;
   rtccal_pkg::time_type   time_q;
   rtccal_pkg::time_type   time_next;
   rtccal_pkg::time_type   head;
   logic                   time_valid_ff, time_valid_in;
   logic                   req_accept;
   logic                   load_en;
   logic                   tick_en;
   logic                   fifo_full;

   assign time_valid_in = (csr_wr_en && (csr_index == rtccal_pkg::CSR_TIME_VALID))
                          ? csr_wdata[0] : time_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_valid_ff <= 1'b0;
      end else begin
         time_valid_ff <= time_valid_in;
      end
   end

   assign req_tready = !rate.busy && !fifo_full;
   assign req_accept = req_tvalid && req_tready;
   assign load_en    = req_accept && (req_tuser == rtccal_pkg::MODE_LOAD);
   assign tick_en    = req_accept && (req_tuser == rtccal_pkg::MODE_TICK)
                       && time_valid_ff && rate.ok;

   assign set.year   = req_tdata[11:0];
   assign set.month  = req_tdata[15:12];
   assign set.day    = req_tdata[20:16];
   assign set.hour   = req_tdata[25:21];
   assign set.minute = req_tdata[31:26];
   assign set.second = req_tdata[37:32];
   assign set.epoch  = req_tdata[69:38];

   rtccal_rate u_rate (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rate      (rate)
   );

   rtccal_core u_core (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .tick_en   (tick_en),
      .set       (set),
      .step      (rate.step),
      .time_q    (time_q),
      .time_next (time_next)
   );

   rtccal_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (time_next),
      .pop       (rsp_tvalid && rsp_tready),
      .full      (fifo_full),
      .not_empty (rsp_tvalid),
      .head      (head)
   );

   assign rsp_tdata = {head.epoch, head.msec, head.second, head.minute,
                       head.hour, head.day, head.month, head.year};

   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      rate.busy |-> !req_tready)
      else $error("request accepted during step calculation");

   a_load_clears_msec: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == rtccal_pkg::MODE_LOAD)) |=> (time_q.msec == '0))
      else $error("load did not clear milliseconds");

   a_msec_in_range: assert property (@(posedge clock) disable iff (reset)
      time_q.msec < rtccal_pkg::MSEC_PER_SEC)
      else $error("millisecond count out of range");

   a_epoch_single_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == rtccal_pkg::MODE_TICK))
      |=> ((time_q.epoch == $past(time_q.epoch))
           || (time_q.epoch == $past(time_q.epoch) + 32'd1)))
      else $error("tick advanced epoch by more than one second");

endmodule
